/* rtl/kpd_evq_pkg.sv */
package kpd_evq_pkg;

    // register map, one word per register
    typedef enum logic [2:0] {
        REG_RIGHT_MAX  = 3'd0,
        REG_UP_MAX     = 3'd1,
        REG_DOWN_MAX   = 3'd2,
        REG_LEFT_MAX   = 3'd3,
        REG_SELECT_MAX = 3'd4,
        REG_MODE_MAX   = 3'd5,
        REG_WHEEL_MAX  = 3'd6,
        REG_INVERT     = 3'd7
    } reg_idx_t;

    // register reset values
    localparam logic [9:0] RST_RIGHT_MAX  = 10'd50;
    localparam logic [9:0] RST_UP_MAX     = 10'd250;
    localparam logic [9:0] RST_DOWN_MAX   = 10'd450;
    localparam logic [9:0] RST_LEFT_MAX   = 10'd650;
    localparam logic [9:0] RST_SELECT_MAX = 10'd850;
    localparam logic [9:0] RST_MODE_MAX   = 10'd250;
    localparam logic [9:0] RST_WHEEL_MAX  = 10'd750;
    localparam logic       RST_INVERT     = 1'b0;

    // event kinds
    localparam logic [3:0] KIND_NONE  = 4'd0;
    localparam logic [3:0] KIND_WHEEL = 4'd8;

    // button bit positions; a button's event kind is its bit position plus one
    localparam int BTN_UP     = 0;
    localparam int BTN_DOWN   = 1;
    localparam int BTN_LEFT   = 2;
    localparam int BTN_RIGHT  = 3;
    localparam int BTN_SELECT = 4;
    localparam int BTN_WHEEL  = 5;
    localparam int BTN_MODE   = 6;
    localparam int NUM_BTNS   = 7;

    // command queue between front and back
    localparam int CMD_FIFO_DEPTH = 2;

    typedef struct packed {
        logic [9:0] right_max;
        logic [9:0] up_max;
        logic [9:0] down_max;
        logic [9:0] left_max;
        logic [9:0] select_max;
        logic [9:0] mode_max;
        logic [9:0] wheel_max;
        logic       invert;
    } cfg_t;

    typedef struct packed {
        logic                pop;
        logic [NUM_BTNS-1:0] pressed;
        logic                wheel_valid;
        logic [7:0]          wheel_amount;
    } cmd_t;

    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] amount;
    } entry_t;

endpackage

/* rtl/keypad_encoder_event_queue.sv */
// Keypad, push button and rotary encoder event queue.
// Input stream (s_): one transaction per item. s_tuser is the opcode:
// 0 samples both ladder levels and the encoder count, 1 pops the oldest
// event. Output stream (m_): exactly one transaction per input item, in
// order. A sample returns kind none; a pop returns the head event, or kind
// none with amount 0 when the ring is empty. events_pending tells whether
// more events wait after that item.
// In order, a sample passes the front end through accept, reciprocal
// multiply, quotient estimate, one correction step and hand-off; the ring
// sequencer then takes the command, writes one event a cycle (at most
// three), closes and presents the result. A pop passes the front through
// accept and hand-off and the sequencer through take command, registered
// ring read and result. The two-entry command queue lets the front take
// the next item while the sequencer is busy or its result waits.
// Reset (synchronous, aresetn low) empties the ring, clears button and
// encoder history and loads the threshold defaults. If m_tready stays low
// the result holds, the command queue fills and s_tready then drops.
// The user must write thresholds over the APB port only while the block is idle; the block does not enforce it.
module keypad_encoder_event_queue #(
    parameter int QUEUE_DEPTH  = 8,
    parameter int ENCODER_STEP = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,  // keypad_level[9:0], button_level[19:10],
                                  // encoder_count[51:20], zero pad [55:52]
    input  logic [0:0]  s_tuser,  // opcode[0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,  // event_amount[7:0], events_pending[8],
                                  // zero pad [15:9]
    output logic [3:0]  m_tuser,  // event_kind[3:0]
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    kpd_evq_pkg::cfg_t     cfg_reg;
    kpd_evq_pkg::reg_idx_t reg_sel;
    logic                  cfg_wr;

    kpd_evq_pkg::cmd_t     front_cmd, back_cmd;
    logic                  front_valid, front_ready;
    logic                  back_valid, back_ready;
    logic [3:0]            event_kind;
    logic signed [7:0]     event_amount;
    logic                  events_pending;

    assign pready  = 1'b1;
    assign reg_sel = kpd_evq_pkg::reg_idx_t'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.right_max  <= kpd_evq_pkg::RST_RIGHT_MAX;
            cfg_reg.up_max     <= kpd_evq_pkg::RST_UP_MAX;
            cfg_reg.down_max   <= kpd_evq_pkg::RST_DOWN_MAX;
            cfg_reg.left_max   <= kpd_evq_pkg::RST_LEFT_MAX;
            cfg_reg.select_max <= kpd_evq_pkg::RST_SELECT_MAX;
            cfg_reg.mode_max   <= kpd_evq_pkg::RST_MODE_MAX;
            cfg_reg.wheel_max  <= kpd_evq_pkg::RST_WHEEL_MAX;
            cfg_reg.invert     <= kpd_evq_pkg::RST_INVERT;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                kpd_evq_pkg::REG_RIGHT_MAX:  cfg_reg.right_max  <= pwdata[9:0];
                kpd_evq_pkg::REG_UP_MAX:     cfg_reg.up_max     <= pwdata[9:0];
                kpd_evq_pkg::REG_DOWN_MAX:   cfg_reg.down_max   <= pwdata[9:0];
                kpd_evq_pkg::REG_LEFT_MAX:   cfg_reg.left_max   <= pwdata[9:0];
                kpd_evq_pkg::REG_SELECT_MAX: cfg_reg.select_max <= pwdata[9:0];
                kpd_evq_pkg::REG_MODE_MAX:   cfg_reg.mode_max   <= pwdata[9:0];
                kpd_evq_pkg::REG_WHEEL_MAX:  cfg_reg.wheel_max  <= pwdata[9:0];
                kpd_evq_pkg::REG_INVERT:     cfg_reg.invert     <= pwdata[0];
            endcase
        end
    end

    // register read-back
    always_comb begin
        unique case (reg_sel)
            kpd_evq_pkg::REG_RIGHT_MAX:  prdata = {22'd0, cfg_reg.right_max};
            kpd_evq_pkg::REG_UP_MAX:     prdata = {22'd0, cfg_reg.up_max};
            kpd_evq_pkg::REG_DOWN_MAX:   prdata = {22'd0, cfg_reg.down_max};
            kpd_evq_pkg::REG_LEFT_MAX:   prdata = {22'd0, cfg_reg.left_max};
            kpd_evq_pkg::REG_SELECT_MAX: prdata = {22'd0, cfg_reg.select_max};
            kpd_evq_pkg::REG_MODE_MAX:   prdata = {22'd0, cfg_reg.mode_max};
            kpd_evq_pkg::REG_WHEEL_MAX:  prdata = {22'd0, cfg_reg.wheel_max};
            kpd_evq_pkg::REG_INVERT:     prdata = {31'd0, cfg_reg.invert};
        endcase
    end

    // classification and encoder division
    kpd_evq_front #(
        .ENCODER_STEP (ENCODER_STEP)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .opcode        (s_tuser[0]),
        .keypad_level  (s_tdata[9:0]),
        .button_level  (s_tdata[19:10]),
        .encoder_count (s_tdata[51:20]),
        .cmd_valid     (front_valid),
        .cmd_ready     (front_ready),
        .cmd           (front_cmd)
    );

    // command queue between the two halves
    kpd_evq_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_cmd    (front_cmd),
        .out_valid (back_valid),
        .out_ready (back_ready),
        .out_cmd   (back_cmd)
    );

    // event ring sequencer
    kpd_evq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd_valid      (back_valid),
        .cmd_ready      (back_ready),
        .cmd            (back_cmd),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .event_kind     (event_kind),
        .event_amount   (event_amount),
        .events_pending (events_pending)
    );

    assign m_tuser = event_kind;
    assign m_tdata = {7'd0, events_pending, event_amount};

endmodule

/* rtl/kpd_evq_ram.sv */
module kpd_evq_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 8,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // single write port, registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/kpd_evq_fifo.sv */
module kpd_evq_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  kpd_evq_pkg::cmd_t   in_cmd,
    output logic                out_valid,
    input  logic                out_ready,
    output kpd_evq_pkg::cmd_t   out_cmd
);

    localparam int DEPTH = kpd_evq_pkg::CMD_FIFO_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    kpd_evq_pkg::cmd_t slot_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              push, pop;

    assign in_ready  = (count_reg != CW'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_cmd   = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // command storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

/* rtl/kpd_evq_front.sv */
module kpd_evq_front #(
    parameter int ENCODER_STEP = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  kpd_evq_pkg::cfg_t  cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               opcode,
    input  logic [9:0]         keypad_level,
    input  logic [9:0]         button_level,
    input  logic signed [31:0] encoder_count,
    output logic               cmd_valid,
    input  logic               cmd_ready,
    output kpd_evq_pkg::cmd_t  cmd
);

    localparam int NB = kpd_evq_pkg::NUM_BTNS;
    // reciprocal of the step scaled by 2^SH; the quotient it gives is at most one low
    localparam int SH = 32 + $clog2(ENCODER_STEP);
    localparam logic [32:0] RECIP   = 33'((64'd1 << SH) / 64'(ENCODER_STEP));
    localparam logic [31:0] DIVISOR = 32'(ENCODER_STEP);

    typedef enum logic [2:0] {
        F_IDLE,
        F_MUL,
        F_EST,
        F_FIX,
        F_PUSH
    } fstate_t;

    fstate_t       state_reg, state_next;
    logic          pop_reg, pop_next;
    logic [NB-1:0] pressed_reg, pressed_next;
    logic [NB-1:0] last_btn_reg, last_btn_next;
    logic [31:0]   last_pos_reg, last_pos_next;
    logic [31:0]   div_reg, div_next;
    logic [64:0]   prod_reg, prod_next;
    logic [31:0]   quot_reg, quot_next;
    logic          neg_reg, neg_next;

    logic [NB-1:0] now_btn;
    logic [31:0]   magnitude;
    logic [31:0]   quot_est;
    logic [31:0]   remainder;
    logic [31:0]   pos;
    logic          accept;

    // ladder classification, thresholds tried in register order, first match wins
    always_comb begin
        now_btn = '0;
        priority if (keypad_level <= cfg.right_max) begin
            now_btn[kpd_evq_pkg::BTN_RIGHT] = 1'b1;
        end else if (keypad_level <= cfg.up_max) begin
            now_btn[kpd_evq_pkg::BTN_UP] = 1'b1;
        end else if (keypad_level <= cfg.down_max) begin
            now_btn[kpd_evq_pkg::BTN_DOWN] = 1'b1;
        end else if (keypad_level <= cfg.left_max) begin
            now_btn[kpd_evq_pkg::BTN_LEFT] = 1'b1;
        end else if (keypad_level <= cfg.select_max) begin
            now_btn[kpd_evq_pkg::BTN_SELECT] = 1'b1;
        end else begin
            // level above every threshold: no key
        end
        priority if (button_level <= cfg.mode_max) begin
            now_btn[kpd_evq_pkg::BTN_MODE] = 1'b1;
        end else if (button_level <= cfg.wheel_max) begin
            now_btn[kpd_evq_pkg::BTN_WHEEL] = 1'b1;
        end else begin
            // level above both thresholds: no button
        end
    end

    assign magnitude = encoder_count[31] ? 32'd0 - encoder_count : encoder_count;

    // quotient estimate from the scaled product, and the remainder it leaves
    assign quot_est  = 32'(prod_reg >> SH);
    assign remainder = div_reg - quot_reg * DIVISOR;

    // truncated quotient with the sign restored
    assign pos = neg_reg ? 32'd0 - quot_reg : quot_reg;

    assign in_ready  = (state_reg == F_IDLE);
    assign accept    = in_valid && in_ready;
    assign cmd_valid = (state_reg == F_PUSH);

    // command towards the ring sequencer
    always_comb begin
        cmd.pop          = pop_reg;
        cmd.pressed      = pressed_reg;
        cmd.wheel_valid  = !pop_reg && (pos != last_pos_reg);
        cmd.wheel_amount = cfg.invert ? last_pos_reg[7:0] - pos[7:0]
                                      : pos[7:0] - last_pos_reg[7:0];
    end

    always_comb begin
        state_next    = state_reg;
        pop_next      = pop_reg;
        pressed_next  = pressed_reg;
        last_btn_next = last_btn_reg;
        last_pos_next = last_pos_reg;
        div_next      = div_reg;
        prod_next     = prod_reg;
        quot_next     = quot_reg;
        neg_next      = neg_reg;
        unique case (state_reg)
            F_IDLE: begin
                if (accept) begin
                    pop_next = opcode;
                    if (opcode) begin
                        state_next = F_PUSH;
                    end else begin
                        pressed_next  = now_btn & ~last_btn_reg;
                        last_btn_next = now_btn;
                        div_next      = magnitude;
                        neg_next      = encoder_count[31];
                        state_next    = F_MUL;
                    end
                end
            end
            F_MUL: begin
                prod_next  = {33'd0, div_reg} * {32'd0, RECIP};
                state_next = F_EST;
            end
            F_EST: begin
                quot_next  = quot_est;
                state_next = F_FIX;
            end
            F_FIX: begin
                if (remainder >= DIVISOR) begin
                    quot_next = quot_reg + 1'b1;
                end
                state_next = F_PUSH;
            end
            F_PUSH: begin
                if (cmd_ready) begin
                    if (cmd.wheel_valid) begin
                        last_pos_next = pos;
                    end
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= F_IDLE;
            last_btn_reg <= '0;
            last_pos_reg <= '0;
        end else begin
            state_reg    <= state_next;
            last_btn_reg <= last_btn_next;
            last_pos_reg <= last_pos_next;
        end
        pop_reg     <= pop_next;
        pressed_reg <= pressed_next;
        div_reg     <= div_next;
        prod_reg    <= prod_next;
        quot_reg    <= quot_next;
        neg_reg     <= neg_next;
    end

endmodule

/* rtl/kpd_evq_back.sv */
module kpd_evq_back #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  kpd_evq_pkg::cmd_t cmd,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [3:0]        event_kind,
    output logic signed [7:0] event_amount,
    output logic              events_pending
);

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int NB = kpd_evq_pkg::NUM_BTNS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_POP,
        ST_OUT
    } state_t;

    state_t        state_reg, state_next;
    logic [IW-1:0] head_reg, head_next;
    logic [IW-1:0] tail_reg, tail_next;
    logic          empty_reg, empty_next;
    logic [3:0]    tail_kind_reg, tail_kind_next;
    logic [7:0]    tail_amt_reg, tail_amt_next;
    logic [NB-1:0] mask_reg, mask_next;
    logic          wheel_reg, wheel_next;
    logic [7:0]    wheel_amt_reg, wheel_amt_next;
    logic [3:0]    out_kind_reg, out_kind_next;
    logic [7:0]    out_amt_reg, out_amt_next;
    logic          out_pend_reg, out_pend_next;

    kpd_evq_pkg::entry_t ram_wdata, ram_rdata;
    logic                ram_we;
    logic [IW-1:0]       ram_waddr;

    logic [3:0]    btn_kind;
    logic [NB-1:0] btn_bit;
    logic          btn_found;
    logic          enq_do;
    logic [3:0]    enq_kind;
    logic [7:0]    enq_amt;
    logic [IW-1:0] tail_inc, head_inc;
    logic          ring_full;

    kpd_evq_ram #(
        .WIDTH ($bits(kpd_evq_pkg::entry_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (head_reg),
        .rd_data (ram_rdata)
    );

    assign tail_inc  = (tail_reg == IW'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
    assign head_inc  = (head_reg == IW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign ring_full = (tail_inc == head_reg);

    // lowest pending button in queue order
    always_comb begin
        btn_kind  = kpd_evq_pkg::KIND_NONE;
        btn_bit   = '0;
        btn_found = 1'b0;
        for (int b = 0; b < NB; b++) begin
            if (mask_reg[b] && !btn_found) begin
                btn_found  = 1'b1;
                btn_kind   = 4'(b + 1);
                btn_bit[b] = 1'b1;
            end
        end
    end

    // event for this cycle: buttons first, then the wheel
    assign enq_do   = (state_reg == ST_EXEC) && (btn_found || wheel_reg);
    assign enq_kind = btn_found ? btn_kind : kpd_evq_pkg::KIND_WHEEL;
    assign enq_amt  = btn_found ? 8'd1 : wheel_amt_reg;

    always_comb begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        empty_next     = empty_reg;
        tail_kind_next = tail_kind_reg;
        tail_amt_next  = tail_amt_reg;
        mask_next      = mask_reg;
        wheel_next     = wheel_reg;
        wheel_amt_next = wheel_amt_reg;
        out_kind_next  = out_kind_reg;
        out_amt_next   = out_amt_reg;
        out_pend_next  = out_pend_reg;
        ram_we         = 1'b0;
        ram_waddr      = tail_reg;
        ram_wdata      = '0;
        cmd_ready      = 1'b0;

        // ring insert: merge into tail, or take the next entry, or drop when full
        if (enq_do && !ring_full) begin
            ram_we = 1'b1;
            if (!empty_reg && (tail_kind_reg == enq_kind)) begin
                tail_amt_next = tail_amt_reg + enq_amt;
                ram_waddr     = tail_reg;
                ram_wdata     = '{kind: tail_kind_reg, amount: tail_amt_reg + enq_amt};
            end else begin
                ram_waddr      = empty_reg ? tail_reg : tail_inc;
                ram_wdata      = '{kind: enq_kind, amount: enq_amt};
                tail_next      = ram_waddr;
                tail_kind_next = enq_kind;
                tail_amt_next  = enq_amt;
                empty_next     = 1'b0;
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                cmd_ready = 1'b1;
                if (cmd_valid) begin
                    if (cmd.pop) begin
                        state_next = ST_POP;
                    end else begin
                        mask_next      = cmd.pressed;
                        wheel_next     = cmd.wheel_valid;
                        wheel_amt_next = cmd.wheel_amount;
                        state_next     = ST_EXEC;
                    end
                end
            end
            ST_EXEC: begin
                if (btn_found) begin
                    mask_next = mask_reg & ~btn_bit;
                end else if (wheel_reg) begin
                    wheel_next = 1'b0;
                end else begin
                    out_kind_next = kpd_evq_pkg::KIND_NONE;
                    out_amt_next  = '0;
                    out_pend_next = !empty_reg;
                    state_next    = ST_OUT;
                end
            end
            ST_POP: begin
                if (!empty_reg) begin
                    out_kind_next = ram_rdata.kind;
                    out_amt_next  = ram_rdata.amount;
                    out_pend_next = (head_reg != tail_reg);
                    if (head_reg == tail_reg) begin
                        empty_next = 1'b1;
                    end else begin
                        head_next = head_inc;
                    end
                end else begin
                    out_kind_next = kpd_evq_pkg::KIND_NONE;
                    out_amt_next  = '0;
                    out_pend_next = 1'b0;
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer state, ring pointers and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            empty_reg <= 1'b1;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            empty_reg <= empty_next;
        end
        tail_kind_reg <= tail_kind_next;
        tail_amt_reg  <= tail_amt_next;
        mask_reg      <= mask_next;
        wheel_reg     <= wheel_next;
        wheel_amt_reg <= wheel_amt_next;
        out_kind_reg  <= out_kind_next;
        out_amt_reg   <= out_amt_next;
        out_pend_reg  <= out_pend_next;
    end

    assign out_valid      = (state_reg == ST_OUT);
    assign event_kind     = out_kind_reg;
    assign event_amount   = out_amt_reg;
    assign events_pending = out_pend_reg;

endmodule

/* sim/keypad_encoder_event_queue_test.sv */
`timescale 1ns / 100ps

module keypad_encoder_event_queue_test;

    localparam int RING_DEPTH  = 8;
    localparam int WHEEL_STEP  = 4;
    localparam int CYCLE_LIMIT = 400000;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_POP    = 1'b1;

    // one result item: kind, amount and the pending flag
    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] amount;
        logic       pending;
    } event_report_t;

    // tracks thresholds, button history, wheel position and the event ring
    class key_event_tracker;
        logic [9:0]    level_max [0:6];
        logic          invert;
        logic [3:0]    ring_kind [RING_DEPTH];
        logic [7:0]    ring_amount [RING_DEPTH];
        int            head;
        int            tail;
        logic [6:0]    held_buttons;
        logic [31:0]   wheel_position;
        event_report_t reports_due [$];
        int            mismatches;

        function new();
            level_max[kpd_evq_pkg::REG_RIGHT_MAX]  = kpd_evq_pkg::RST_RIGHT_MAX;
            level_max[kpd_evq_pkg::REG_UP_MAX]     = kpd_evq_pkg::RST_UP_MAX;
            level_max[kpd_evq_pkg::REG_DOWN_MAX]   = kpd_evq_pkg::RST_DOWN_MAX;
            level_max[kpd_evq_pkg::REG_LEFT_MAX]   = kpd_evq_pkg::RST_LEFT_MAX;
            level_max[kpd_evq_pkg::REG_SELECT_MAX] = kpd_evq_pkg::RST_SELECT_MAX;
            level_max[kpd_evq_pkg::REG_MODE_MAX]   = kpd_evq_pkg::RST_MODE_MAX;
            level_max[kpd_evq_pkg::REG_WHEEL_MAX]  = kpd_evq_pkg::RST_WHEEL_MAX;
            invert = kpd_evq_pkg::RST_INVERT;
            for (int i = 0; i < RING_DEPTH; i++) begin
                ring_kind[i]   = kpd_evq_pkg::KIND_NONE;
                ring_amount[i] = 8'd0;
            end
            head = 0;
            tail = 0;
            held_buttons = '0;
            wheel_position = '0;
            mismatches = 0;
        endfunction

        function void load_register(kpd_evq_pkg::reg_idx_t idx, logic [31:0] value);
            if (idx == kpd_evq_pkg::REG_INVERT)
                invert = value[0];
            else
                level_max[idx] = value[9:0];
        endfunction

        function logic [31:0] register_value(kpd_evq_pkg::reg_idx_t idx);
            if (idx == kpd_evq_pkg::REG_INVERT)
                return {31'd0, invert};
            return {22'd0, level_max[idx]};
        endfunction

        function int next_slot(int i);
            return (i + 1 >= RING_DEPTH) ? 0 : i + 1;
        endfunction

        // full ring drops the event, a repeated kind adds into the tail entry
        function void push_event(logic [3:0] kind, logic [7:0] amount);
            if (next_slot(tail) == head)
                return;
            if (ring_kind[tail] == kind) begin
                ring_amount[tail] = ring_amount[tail] + amount;
                return;
            end
            if (ring_kind[tail] != kpd_evq_pkg::KIND_NONE)
                tail = next_slot(tail);
            ring_kind[tail]   = kind;
            ring_amount[tail] = amount;
        endfunction

        function void note_item(logic op, logic [9:0] kp, logic [9:0] bl, logic [31:0] enc);
            logic [6:0]    now;
            logic [6:0]    fresh;
            int            count;
            logic [31:0]   pos;
            logic [31:0]   diff;
            event_report_t r;
            r.kind = kpd_evq_pkg::KIND_NONE;
            r.amount = 8'd0;
            if (op == OP_SAMPLE) begin
                now = '0;
                if (kp <= level_max[kpd_evq_pkg::REG_RIGHT_MAX])
                    now[kpd_evq_pkg::BTN_RIGHT] = 1'b1;
                else if (kp <= level_max[kpd_evq_pkg::REG_UP_MAX])
                    now[kpd_evq_pkg::BTN_UP] = 1'b1;
                else if (kp <= level_max[kpd_evq_pkg::REG_DOWN_MAX])
                    now[kpd_evq_pkg::BTN_DOWN] = 1'b1;
                else if (kp <= level_max[kpd_evq_pkg::REG_LEFT_MAX])
                    now[kpd_evq_pkg::BTN_LEFT] = 1'b1;
                else if (kp <= level_max[kpd_evq_pkg::REG_SELECT_MAX])
                    now[kpd_evq_pkg::BTN_SELECT] = 1'b1;
                if (bl <= level_max[kpd_evq_pkg::REG_MODE_MAX])
                    now[kpd_evq_pkg::BTN_MODE] = 1'b1;
                else if (bl <= level_max[kpd_evq_pkg::REG_WHEEL_MAX])
                    now[kpd_evq_pkg::BTN_WHEEL] = 1'b1;
                // newly pressed buttons in bit order
                fresh = now & ~held_buttons;
                for (int b = 0; b < kpd_evq_pkg::NUM_BTNS; b++)
                    if (fresh[b])
                        push_event(4'(b + 1), 8'd1);
                held_buttons = now;
                // signed division truncates toward zero
                count = enc;
                pos = count / WHEEL_STEP;
                if (pos != wheel_position) begin
                    diff = pos - wheel_position;
                    if (invert)
                        diff = -diff;
                    push_event(kpd_evq_pkg::KIND_WHEEL, diff[7:0]);
                    wheel_position = pos;
                end
            end else if (ring_kind[head] != kpd_evq_pkg::KIND_NONE) begin
                r.kind   = ring_kind[head];
                r.amount = ring_amount[head];
                ring_kind[head]   = kpd_evq_pkg::KIND_NONE;
                ring_amount[head] = 8'd0;
                if (head != tail)
                    head = next_slot(head);
            end
            r.pending = (ring_kind[head] != kpd_evq_pkg::KIND_NONE);
            reports_due.push_back(r);
        endfunction

        function void check_report(logic [3:0] kind, logic [7:0] amount, logic pending);
            event_report_t want;
            if (reports_due.size() == 0) begin
                $display("%0t: result with no item waiting: kind %0d amount %0d pending %0d",
                         $time, kind, amount, pending);
                mismatches++;
                return;
            end
            want = reports_due.pop_front();
            if (kind !== want.kind) begin
                $display("%0t: event_kind expected %0d actual %0d", $time, want.kind, kind);
                mismatches++;
            end
            if (amount !== want.amount) begin
                $display("%0t: event_amount expected %0d actual %0d",
                         $time, $signed(want.amount), $signed(amount));
                mismatches++;
            end
            if (pending !== want.pending) begin
                $display("%0t: events_pending expected %0d actual %0d",
                         $time, want.pending, pending);
                mismatches++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata  = '0;
    logic [0:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [4:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    key_event_tracker tracker;
    int               cycle_count = 0;
    int               readback_errors = 0;
    int               wheel_count = 0;
    logic [9:0]       last_kp = '0;
    logic [9:0]       last_bl = '0;

    keypad_encoder_event_queue #(
        .QUEUE_DEPTH  (RING_DEPTH),
        .ENCODER_STEP (WHEEL_STEP)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // result side: check each transaction, stall on a rotating pattern
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            tracker.check_report(m_tuser, m_tdata[7:0], m_tdata[8]);
        case ((cycle_count / 256) % 4)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            2: m_tready <= ((cycle_count % 16) >= 5);
            default: m_tready <= 1'($urandom_range(0, 1));
        endcase
    end

    // one input transaction, returns at the accepting edge
    task automatic send_item(input logic op, input logic [9:0] kp, input logic [9:0] bl,
                             input logic [31:0] enc);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'd0, enc, bl, kp};
        do @(posedge aclk); while (!s_tready);
        tracker.note_item(op, kp, bl, enc);
    endtask

    task automatic pop_head();
        send_item(OP_POP, 10'($urandom), 10'($urandom), $urandom);
    endtask

    task automatic sender_gap(input int cycles);
        if (cycles > 0) begin
            s_tvalid <= 1'b0;
            repeat (cycles) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (tracker.reports_due.size() != 0)
            @(posedge aclk);
    endtask

    // write with noise above the field, then read back
    task automatic reg_write(input kpd_evq_pkg::reg_idx_t idx, input logic [9:0] level);
        logic [31:0] value;
        value = {22'($urandom), level};
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        tracker.load_register(idx, value);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== tracker.register_value(idx)) begin
            $display("%0t: register %0d read expected %0h actual %0h",
                     $time, idx, tracker.register_value(idx), prdata);
            readback_errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_all(input logic [9:0] rt, input logic [9:0] up, input logic [9:0] dn,
                           input logic [9:0] lf, input logic [9:0] sl, input logic [9:0] md,
                           input logic [9:0] wh, input logic inv);
        reg_write(kpd_evq_pkg::REG_RIGHT_MAX, rt);
        reg_write(kpd_evq_pkg::REG_UP_MAX, up);
        reg_write(kpd_evq_pkg::REG_DOWN_MAX, dn);
        reg_write(kpd_evq_pkg::REG_LEFT_MAX, lf);
        reg_write(kpd_evq_pkg::REG_SELECT_MAX, sl);
        reg_write(kpd_evq_pkg::REG_MODE_MAX, md);
        reg_write(kpd_evq_pkg::REG_WHEEL_MAX, wh);
        reg_write(kpd_evq_pkg::REG_INVERT, {9'd0, inv});
    endtask

    // ascending random thresholds, keypad and button ladders each ordered
    task automatic set_ordered();
        logic [9:0] th [0:6];
        int         acc;
        acc = 0;
        for (int i = 0; i < 5; i++) begin
            acc = acc + $urandom_range(0, 260);
            if (acc > 1023)
                acc = 1023;
            th[i] = 10'(acc);
        end
        th[5] = 10'($urandom_range(0, 700));
        th[6] = th[5] + 10'($urandom_range(0, 323));
        set_all(th[0], th[1], th[2], th[3], th[4], th[5], th[6], 1'($urandom_range(0, 1)));
    endtask

    function automatic logic [9:0] pick_level(input logic [9:0] prev);
        case ($urandom_range(0, 9))
            0, 1, 2: return prev;
            3: return 10'd0;
            4: return 10'd1023;
            default: return 10'($urandom_range(0, 1023));
        endcase
    endfunction

    // mostly small encoder moves with held or changing levels, some pops
    task automatic run_phase(input int items, input int pop_pct, input bit steady);
        int left_in_burst;
        left_in_burst = $urandom_range(1, 12);
        for (int n = 0; n < items; n++) begin
            if ($urandom_range(0, 99) < pop_pct) begin
                pop_head();
            end else begin
                case ($urandom_range(0, 19))
                    0, 1: wheel_count = $urandom;
                    2, 3: wheel_count = wheel_count + ($urandom_range(0, 1) ? 1024 : -1024);
                    default: wheel_count = wheel_count + int'($urandom_range(0, 40)) - 20;
                endcase
                last_kp = pick_level(last_kp);
                last_bl = pick_level(last_bl);
                send_item(OP_SAMPLE, last_kp, last_bl, wheel_count);
            end
            left_in_burst--;
            if (left_in_burst == 0) begin
                left_in_burst = $urandom_range(1, 12);
                if (!steady)
                    sender_gap($urandom_range(0, 6));
            end
        end
        wait_drained();
    endtask

    initial begin
        tracker = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty pop, every key zone, both buttons, encoder extremes
        pop_head();
        send_item(OP_SAMPLE, 10'd0, 10'd0, 32'd0);
        send_item(OP_SAMPLE, 10'd1023, 10'd1023, 32'd4);
        // wheel delta of 256 wraps to amount zero
        send_item(OP_SAMPLE, 10'd100, 10'd500, 32'd1028);
        send_item(OP_SAMPLE, 10'd300, 10'd1023, 32'd1028);
        send_item(OP_SAMPLE, 10'd500, 10'd1023, 32'h7FFF_FFFF);
        send_item(OP_SAMPLE, 10'd700, 10'd1023, 32'h8000_0000);
        send_item(OP_SAMPLE, 10'd900, 10'd1023, -32'sd3);
        // ring full here, events dropped
        send_item(OP_SAMPLE, 10'd0, 10'd0, -32'sd4);
        // drain, last pops find the ring empty
        repeat (9) pop_head();
        // repeated wheel kind adds into the tail entry
        send_item(OP_SAMPLE, 10'd1023, 10'd1023, -32'sd9);
        send_item(OP_SAMPLE, 10'd1023, 10'd1023, -32'sd13);
        pop_head();
        // repeated key press adds into the tail entry
        send_item(OP_SAMPLE, 10'd0, 10'd1023, -32'sd13);
        send_item(OP_SAMPLE, 10'd1023, 10'd1023, -32'sd13);
        send_item(OP_SAMPLE, 10'd0, 10'd1023, -32'sd13);
        pop_head();
        wheel_count = -13;
        wait_drained();

        // random phases over several threshold settings
        set_all(10'd50, 10'd250, 10'd450, 10'd650, 10'd850, 10'd250, 10'd750, 1'b1);
        run_phase(160, 35, 1'b0);
        set_all(10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 1'b0);
        run_phase(130, 50, 1'b0);
        set_all(10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 1'b1);
        run_phase(100, 50, 1'b0);
        set_ordered();
        run_phase(180, 20, 1'b0);
        set_all(10'($urandom), 10'($urandom), 10'($urandom), 10'($urandom), 10'($urandom),
                10'($urandom), 10'($urandom), 1'($urandom_range(0, 1)));
        run_phase(180, 60, 1'b0);
        set_ordered();
        run_phase(180, 45, 1'b1);

        repeat (30) @(posedge aclk);
        if (tracker.mismatches == 0 && readback_errors == 0 && tracker.reports_due.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* files.f */
rtl/kpd_evq_pkg.sv
rtl/kpd_evq_ram.sv
rtl/kpd_evq_fifo.sv
rtl/kpd_evq_front.sv
rtl/kpd_evq_back.sv
rtl/keypad_encoder_event_queue.sv
sim/keypad_encoder_event_queue_test.sv
